// File: rtl/scc_pkg.sv
`default_nettype none

package scc_pkg;

  // Chunk geometry limits.
  localparam int CHUNK_ROWS = 64;
  localparam int MAP_DIM    = 4096;

  // Field widths.
  localparam int POS_W    = 24;
  localparam int DIFF_W   = POS_W + 1;
  localparam int VIEW_W   = 16;
  localparam int RAD_W    = 23;
  localparam int IDX_W    = 12;
  localparam int VERT_W   = 25;
  localparam int COUNT_W  = 14;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Shared multiplier and accumulator widths.
  localparam int MUL_W    = 26;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DIST2_W  = 50;
  localparam int REACH2_W = 48;
  localparam int RAD2_W   = 46;
  localparam int DOT_W    = 43;
  localparam int BASE_W   = 24;

  // Row counter of the emitter.
  localparam int ROWS_W = (CHUNK_ROWS > 1) ? $clog2(CHUNK_ROWS) : 1;
  localparam logic [IDX_W-1:0] ROWS_MAX  = IDX_W'(CHUNK_ROWS - 1);
  localparam logic [IDX_W-1:0] PAIRS_MAX = IDX_W'(MAP_DIM - 1);

  // Job queue between classifier and emitter.
  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAM_X    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Z    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_X   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_Z   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAIRS    = 4'd7;

  // Multiplier step codes, issued in this order.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_DXX   = 4'd0;
  localparam logic [OP_W-1:0] OP_DYY   = 4'd1;
  localparam logic [OP_W-1:0] OP_DZZ   = 4'd2;
  localparam logic [OP_W-1:0] OP_DXV   = 4'd3;
  localparam logic [OP_W-1:0] OP_DYV   = 4'd4;
  localparam logic [OP_W-1:0] OP_DZV   = 4'd5;
  localparam logic [OP_W-1:0] OP_REACH = 4'd6;
  localparam logic [OP_W-1:0] OP_RAD   = 4'd7;
  localparam logic [OP_W-1:0] OP_BASE  = 4'd8;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  cam_x;
    logic signed [POS_W-1:0]  cam_y;
    logic signed [POS_W-1:0]  cam_z;
    logic signed [VIEW_W-1:0] view_x;
    logic signed [VIEW_W-1:0] view_y;
    logic signed [VIEW_W-1:0] view_z;
    logic [RAD_W-1:0]         max_distance;
    logic [IDX_W-1:0]         pairs_per_row;
  } cfg_t;

  typedef struct packed {
    logic [VERT_W-1:0]  vertex;
    logic [IDX_W:0]     vstep;
    logic [ROWS_W-1:0]  rows_m1;
    logic [COUNT_W-1:0] count;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/sphere_chunk_cull_row_emitter.sv
// A chunk on push passes the classifier's calc and push states, the job queue and the
// emitter's output register. The classifier takes a new chunk only when idle, as its
// single shared multiplier forms nine products in turn; the emitter gives one row beat
// per cycle while pop keeps up, and takes a job from the two-entry queue only when idle.
// Reset (rst, synchronous): queues empty, sequencer idle, registers at their reset values;
// no clearing pass, the block accepts items on the first cycle after reset.
`default_nettype none

module sphere_chunk_cull_row_emitter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [scc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [scc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [scc_pkg::POS_W-1:0]    center_x,
  input  wire logic signed [scc_pkg::POS_W-1:0]    center_y,
  input  wire logic signed [scc_pkg::POS_W-1:0]    center_z,
  input  wire logic [scc_pkg::RAD_W-1:0]           sphere_radius,
  input  wire logic [scc_pkg::IDX_W-1:0]           first_row,
  input  wire logic [scc_pkg::IDX_W-1:0]           final_row,
  input  wire logic [scc_pkg::IDX_W-1:0]           first_pair,
  input  wire logic [scc_pkg::IDX_W-1:0]           final_pair,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [scc_pkg::VERT_W-1:0]               first_vertex,
  output logic [scc_pkg::COUNT_W-1:0]              vertex_count,
  output logic                                     last_row
);

  scc_pkg::cfg_t cfg;
  scc_pkg::job_t push_job, pop_job;
  logic          job_push, job_full, job_take, job_avail;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_x         <= '0;
      cfg.cam_y         <= '0;
      cfg.cam_z         <= '0;
      cfg.view_x        <= '0;
      cfg.view_y        <= '0;
      cfg.view_z        <= 16'sd16384;
      cfg.max_distance  <= '1;
      cfg.pairs_per_row <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scc_pkg::REG_CAM_X:    cfg.cam_x         <= cfg_data[scc_pkg::POS_W-1:0];
        scc_pkg::REG_CAM_Y:    cfg.cam_y         <= cfg_data[scc_pkg::POS_W-1:0];
        scc_pkg::REG_CAM_Z:    cfg.cam_z         <= cfg_data[scc_pkg::POS_W-1:0];
        scc_pkg::REG_VIEW_X:   cfg.view_x        <= cfg_data[scc_pkg::VIEW_W-1:0];
        scc_pkg::REG_VIEW_Y:   cfg.view_y        <= cfg_data[scc_pkg::VIEW_W-1:0];
        scc_pkg::REG_VIEW_Z:   cfg.view_z        <= cfg_data[scc_pkg::VIEW_W-1:0];
        scc_pkg::REG_MAX_DIST: cfg.max_distance  <= cfg_data[scc_pkg::RAD_W-1:0];
        scc_pkg::REG_PAIRS:    cfg.pairs_per_row <= cfg_data[scc_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: cull tests and job setup.
  scc_classify u_classify (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .push          (push),
    .full          (full),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius),
    .first_row     (first_row),
    .final_row     (final_row),
    .first_pair    (first_pair),
    .final_pair    (final_pair),
    .job           (push_job),
    .job_push      (job_push),
    .job_full      (job_full)
  );

  // Queue of visible chunks.
  scc_job_fifo u_job_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (push_job),
    .full   (job_full),
    .rd_en  (job_take),
    .rd_job (pop_job),
    .avail  (job_avail)
  );

  // Back: one draw range per row.
  scc_row_emit u_row_emit (
    .clk          (clk),
    .rst          (rst),
    .job          (pop_job),
    .job_avail    (job_avail),
    .job_take     (job_take),
    .empty        (empty),
    .pop          (pop),
    .first_vertex (first_vertex),
    .vertex_count (vertex_count),
    .last_row     (last_row)
  );

endmodule

`default_nettype wire

// File: rtl/scc_classify.sv
`default_nettype none

module scc_classify (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire scc_pkg::cfg_t                   cfg,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic signed [scc_pkg::POS_W-1:0] center_x,
  input  wire logic signed [scc_pkg::POS_W-1:0] center_y,
  input  wire logic signed [scc_pkg::POS_W-1:0] center_z,
  input  wire logic [scc_pkg::RAD_W-1:0]       sphere_radius,
  input  wire logic [scc_pkg::IDX_W-1:0]       first_row,
  input  wire logic [scc_pkg::IDX_W-1:0]       final_row,
  input  wire logic [scc_pkg::IDX_W-1:0]       first_pair,
  input  wire logic [scc_pkg::IDX_W-1:0]       final_pair,
  output scc_pkg::job_t                        job,
  output logic                                 job_push,
  input  wire logic                            job_full
);

  scc_pkg::front_state_t state, state_next;

  logic signed [scc_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [scc_pkg::RAD_W-1:0]         rad;
  logic [scc_pkg::IDX_W-1:0]         row0, row1, pair0, pair1;
  logic [scc_pkg::OP_W-1:0]          step;
  logic signed [scc_pkg::PROD_W-1:0] prod;
  logic [scc_pkg::OP_W-1:0]          prod_op;
  logic                              prod_vld;
  logic [scc_pkg::DIST2_W-1:0]       dist2;
  logic signed [scc_pkg::DOT_W-1:0]  dot;
  logic [scc_pkg::REACH2_W-1:0]      reach2;
  logic [scc_pkg::RAD2_W-1:0]        rad2;
  logic [scc_pkg::BASE_W-1:0]        base;

  logic                              accept;
  logic                              issue;
  logic                              calc_done;
  logic                              visible;
  logic                              rows_ok;
  logic signed [scc_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [scc_pkg::PROD_W-1:0] mul_res;
  logic [scc_pkg::RAD_W:0]           reach;
  logic [scc_pkg::IDX_W-1:0]         pairs_eff;
  logic signed [scc_pkg::DOT_W-1:0]  neg_rad14;
  logic [scc_pkg::IDX_W-1:0]         row_span;
  logic [scc_pkg::IDX_W:0]           pair_span;
  logic [scc_pkg::BASE_W:0]          vert_half;

  function automatic logic signed [scc_pkg::DIFF_W-1:0] DIFF_EXT(
    input logic signed [scc_pkg::POS_W-1:0] v
  );
    return {v[scc_pkg::POS_W-1], v};
  endfunction

  // Derived quantities.
  assign reach     = {1'b0, cfg.max_distance} + {1'b0, rad};
  assign pairs_eff = (cfg.pairs_per_row > scc_pkg::PAIRS_MAX) ?
                     scc_pkg::PAIRS_MAX : cfg.pairs_per_row;
  assign neg_rad14 = -$signed({{(scc_pkg::DOT_W - scc_pkg::RAD_W - 14){1'b0}}, rad, 14'b0});
  assign row_span  = row1 - row0;
  assign pair_span = {1'b0, pair1 - pair0} + {{scc_pkg::IDX_W{1'b0}}, 1'b1};
  assign vert_half = {1'b0, base} + {{(scc_pkg::BASE_W - scc_pkg::IDX_W + 1){1'b0}}, pair0};

  // Cull decision on the finished sums.
  assign rows_ok = (row1 >= row0);
  assign visible = !(dist2 > {{(scc_pkg::DIST2_W - scc_pkg::REACH2_W){1'b0}}, reach2}) &&
                   !((dist2 > {{(scc_pkg::DIST2_W - scc_pkg::RAD2_W){1'b0}}, rad2}) &&
                     (dot < neg_rad14));

  // Job built from the chunk.
  always_comb begin
    job.vertex  = {vert_half[scc_pkg::VERT_W-2:0], 1'b0};
    job.vstep   = {pairs_eff, 1'b0};
    job.rows_m1 = (row_span > scc_pkg::ROWS_MAX) ? scc_pkg::ROWS_MAX[scc_pkg::ROWS_W-1:0]
                                                 : row_span[scc_pkg::ROWS_W-1:0];
    job.count   = (pair1 >= pair0) ? {pair_span, 1'b0} : '0;
  end

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      scc_pkg::OP_DXX: begin
        mul_a = scc_pkg::MUL_W'(dx);
        mul_b = scc_pkg::MUL_W'(dx);
      end
      scc_pkg::OP_DYY: begin
        mul_a = scc_pkg::MUL_W'(dy);
        mul_b = scc_pkg::MUL_W'(dy);
      end
      scc_pkg::OP_DZZ: begin
        mul_a = scc_pkg::MUL_W'(dz);
        mul_b = scc_pkg::MUL_W'(dz);
      end
      scc_pkg::OP_DXV: begin
        mul_a = scc_pkg::MUL_W'(dx);
        mul_b = scc_pkg::MUL_W'(cfg.view_x);
      end
      scc_pkg::OP_DYV: begin
        mul_a = scc_pkg::MUL_W'(dy);
        mul_b = scc_pkg::MUL_W'(cfg.view_y);
      end
      scc_pkg::OP_DZV: begin
        mul_a = scc_pkg::MUL_W'(dz);
        mul_b = scc_pkg::MUL_W'(cfg.view_z);
      end
      scc_pkg::OP_REACH: begin
        mul_a = $signed({2'b0, reach});
        mul_b = $signed({2'b0, reach});
      end
      scc_pkg::OP_RAD: begin
        mul_a = $signed({3'b0, rad});
        mul_b = $signed({3'b0, rad});
      end
      scc_pkg::OP_BASE: begin
        mul_a = $signed({{(scc_pkg::MUL_W - scc_pkg::IDX_W){1'b0}}, row0});
        mul_b = $signed({{(scc_pkg::MUL_W - scc_pkg::IDX_W){1'b0}}, pairs_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // The last product lands in the accumulators this cycle.
  assign calc_done = prod_vld && (prod_op == scc_pkg::OP_BASE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      scc_pkg::F_IDLE: if (push) state_next = scc_pkg::F_CALC;
      scc_pkg::F_CALC: if (calc_done) state_next = scc_pkg::F_PUSH;
      scc_pkg::F_PUSH: if (!(visible && rows_ok) || !job_full) state_next = scc_pkg::F_IDLE;
      default:         state_next = scc_pkg::F_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    full     = 1'b1;
    accept   = 1'b0;
    issue    = 1'b0;
    job_push = 1'b0;
    unique case (state)
      scc_pkg::F_IDLE: begin
        full   = 1'b0;
        accept = push;
      end
      scc_pkg::F_CALC: issue = (step <= scc_pkg::OP_BASE);
      scc_pkg::F_PUSH: job_push = visible && rows_ok && !job_full;
      default: ;
    endcase
  end

  // State and multiplier pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= scc_pkg::F_IDLE;
      prod_vld <= 1'b0;
      step     <= '0;
    end else begin
      state    <= state_next;
      prod_vld <= issue;
      if (accept) begin
        step <= '0;
      end else if (issue) begin
        step <= step + 1'b1;
      end
    end
  end

  // Chunk fields, products and sums.
  always_ff @(posedge clk) begin
    if (accept) begin
      dx    <= DIFF_EXT(center_x) - DIFF_EXT(cfg.cam_x);
      dy    <= DIFF_EXT(center_y) - DIFF_EXT(cfg.cam_y);
      dz    <= DIFF_EXT(center_z) - DIFF_EXT(cfg.cam_z);
      rad   <= sphere_radius;
      row0  <= first_row;
      row1  <= final_row;
      pair0 <= first_pair;
      pair1 <= final_pair;
      dist2 <= '0;
      dot   <= '0;
    end else if (prod_vld) begin
      unique case (prod_op)
        scc_pkg::OP_DXX, scc_pkg::OP_DYY, scc_pkg::OP_DZZ:
          dist2 <= dist2 + prod[scc_pkg::DIST2_W-1:0];
        scc_pkg::OP_DXV, scc_pkg::OP_DYV, scc_pkg::OP_DZV:
          dot <= dot + $signed(prod[scc_pkg::DOT_W-1:0]);
        scc_pkg::OP_REACH: reach2 <= prod[scc_pkg::REACH2_W-1:0];
        scc_pkg::OP_RAD:   rad2   <= prod[scc_pkg::RAD2_W-1:0];
        scc_pkg::OP_BASE:  base   <= prod[scc_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
    if (issue) begin
      prod    <= mul_res;
      prod_op <= step;
    end
  end

endmodule

`default_nettype wire

// File: rtl/scc_job_fifo.sv
`default_nettype none

module scc_job_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire scc_pkg::job_t wr_job,
  output logic               full,
  input  wire logic          rd_en,
  output scc_pkg::job_t      rd_job,
  output logic               avail
);

  scc_pkg::job_t                 slots [scc_pkg::JOB_DEPTH];
  logic [scc_pkg::JOB_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [scc_pkg::JOB_CNT_W-1:0] fill;

  assign full   = (fill == scc_pkg::JOB_CNT_W'(scc_pkg::JOB_DEPTH));
  assign avail  = (fill != '0);
  assign rd_job = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == scc_pkg::JOB_PTR_W'(scc_pkg::JOB_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == scc_pkg::JOB_PTR_W'(scc_pkg::JOB_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

`default_nettype wire

// File: rtl/scc_row_emit.sv
`default_nettype none

module scc_row_emit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire scc_pkg::job_t                   job,
  input  wire logic                            job_avail,
  output logic                                 job_take,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [scc_pkg::VERT_W-1:0]           first_vertex,
  output logic [scc_pkg::COUNT_W-1:0]          vertex_count,
  output logic                                 last_row
);

  logic                         active;
  logic [scc_pkg::VERT_W-1:0]   cur_vertex;
  logic [scc_pkg::IDX_W:0]      cur_step;
  logic [scc_pkg::ROWS_W-1:0]   rows_left;
  logic [scc_pkg::COUNT_W-1:0]  cur_count;
  logic                         out_valid;
  logic                         load;

  assign empty    = !out_valid;
  assign job_take = !active && job_avail;
  assign load     = active && (!out_valid || pop);

  // Control: job ownership and output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_take) begin
        active <= 1'b1;
      end else if (load && (rows_left == '0)) begin
        active <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Row walker and output beat register.
  always_ff @(posedge clk) begin
    if (job_take) begin
      cur_vertex <= job.vertex;
      cur_step   <= job.vstep;
      rows_left  <= job.rows_m1;
      cur_count  <= job.count;
    end else if (load) begin
      cur_vertex <= cur_vertex + scc_pkg::VERT_W'(cur_step);
      rows_left  <= rows_left - 1'b1;
    end
    if (load) begin
      first_vertex <= cur_vertex;
      vertex_count <= cur_count;
      last_row     <= (rows_left == '0);
    end
  end

  // A taken job starts the walker.
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    job_take |=> active)
    else $error("job taken but emitter not active");

  // Rows remain after a non-final beat.
  a_rows_continue: assert property (@(posedge clk) disable iff (rst)
    (load && (rows_left != '0)) |=> active)
    else $error("emitter dropped a job before its last row");

  // The walker holds its position between beats.
  a_walker_holds: assert property (@(posedge clk) disable iff (rst)
    (active && !load) |=> $stable(cur_vertex) && $stable(rows_left))
    else $error("row walker moved without a beat");

endmodule

`default_nettype wire
